@@ hw/rtl/overwrite_ring_message_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// overwrite_ring_message_queue_core_macros
// Assertion helpers shared by the queue core.
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_RING_MESSAGE_QUEUE_CORE_MACROS_SVH
`define OVERWRITE_RING_MESSAGE_QUEUE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ORQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed");

// next-cycle implication, disabled while in reset
`define ORQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

@@ hw/rtl/orq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orq_pkg
// Sizes, codes and controller/datapath interface types of the message queue.
// ----------------------------------------------------------------------------
package orq_pkg;

    localparam int MSG_BYTES  = 32;
    localparam int SLOT_COUNT = 256;
    localparam int EOM_POS    = 1;
    localparam int EOM_MASK   = 63;

    // byte that carries the end-of-message index
    localparam int EOM_SRC = (EOM_POS < MSG_BYTES) ? EOM_POS : 0;

    localparam int BYTE_W  = 8;
    localparam int OP_W    = 2;
    localparam int EOM_W   = 6;
    localparam int COUNT_W = 9;
    localparam int IDX_W   = $clog2(MSG_BYTES);
    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ADDR_W  = $clog2(SLOT_COUNT * MSG_BYTES);
    localparam int CFG_W   = 1;

    localparam logic [CFG_W-1:0] CFG_SAMPLING = 1'b0;
    localparam logic [CFG_W-1:0] CFG_SENDING  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_READ   = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_RESP,
        ST_RD_ADDR,
        ST_RD_DATA
    } state_t;

    typedef struct packed {
        logic flags_clr;
        logic stage_push;
        logic idx_clr;
        logic idx_inc;
        logic copy_wr;
        logic commit;
        logic set_empty;
        logic del;
        logic rd_en;
        logic load_byte;
        logic load_resp;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic gate_open;
        logic held_zero;
        logic idx_last;
        logic out_free;
    } status_t;

endpackage

@@ hw/rtl/orq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orq_ctrl
// Sequencer for push, commit copy, read stream, delete and single responses.
// ----------------------------------------------------------------------------
module orq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  orq_pkg::op_t      op,
    input  orq_pkg::status_t  status,
    output orq_pkg::cmd_t     cmd
);

    orq_pkg::state_t state_reg;
    orq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= orq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            orq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.flags_clr = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    case (op)
                        orq_pkg::OP_PUSH: begin
                            cmd.stage_push = 1'b1;
                            if (status.fill_last && status.gate_open) begin
                                state_next = orq_pkg::ST_COPY;
                            end else begin
                                state_next = orq_pkg::ST_RESP;
                            end
                        end
                        orq_pkg::OP_READ: begin
                            if (status.held_zero) begin
                                cmd.set_empty = 1'b1;
                                state_next    = orq_pkg::ST_RESP;
                            end else begin
                                state_next = orq_pkg::ST_RD_ADDR;
                            end
                        end
                        orq_pkg::OP_DELETE: begin
                            cmd.set_empty = status.held_zero;
                            cmd.del       = !status.held_zero;
                            state_next    = orq_pkg::ST_RESP;
                        end
                        default: begin
                            state_next = orq_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            orq_pkg::ST_COPY: begin
                cmd.copy_wr = 1'b1;
                if (status.idx_last) begin
                    cmd.commit = 1'b1;
                    state_next = orq_pkg::ST_RESP;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            orq_pkg::ST_RESP: begin
                if (status.out_free) begin
                    cmd.load_resp = 1'b1;
                    state_next    = orq_pkg::ST_IDLE;
                end
            end
            orq_pkg::ST_RD_ADDR: begin
                cmd.rd_en  = 1'b1;
                state_next = orq_pkg::ST_RD_DATA;
            end
            orq_pkg::ST_RD_DATA: begin
                // read data holds until the next address is issued
                if (status.out_free) begin
                    cmd.load_byte = 1'b1;
                    if (status.idx_last) begin
                        state_next = orq_pkg::ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = orq_pkg::ST_RD_ADDR;
                    end
                end
            end
            default: begin
                state_next = orq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/orq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orq_datapath
// Staging buffer, slot memory, ring pointers, counts and result register.
// ----------------------------------------------------------------------------
module orq_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  orq_pkg::cmd_t                 cmd,
    output orq_pkg::status_t              status,
    input  logic [orq_pkg::BYTE_W-1:0]    byte_in,
    input  logic                          cfg_we,
    input  logic [orq_pkg::CFG_W-1:0]     cfg_addr,
    input  logic                          cfg_wdata,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [31:0]                   m_tdata,
    output logic                          m_tlast,
    output logic [2:0]                    m_tuser
);

    localparam logic [orq_pkg::SLOT_W-1:0] SLOT_MAX = orq_pkg::SLOT_W'(orq_pkg::SLOT_COUNT - 1);
    localparam logic [orq_pkg::IDX_W-1:0]  IDX_MAX  = orq_pkg::IDX_W'(orq_pkg::MSG_BYTES - 1);
    localparam logic [orq_pkg::IDX_W-1:0]  IDX_EOM  = orq_pkg::IDX_W'(orq_pkg::EOM_SRC);

    function automatic logic [orq_pkg::SLOT_W-1:0] next_slot(
        input logic [orq_pkg::SLOT_W-1:0] s
    );
        if (s == SLOT_MAX) begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    logic                          sampling_reg;
    logic                          sending_reg;
    logic [orq_pkg::IDX_W-1:0]     fill_reg;
    logic [orq_pkg::BYTE_W-1:0]    staging_reg [orq_pkg::MSG_BYTES];
    logic [orq_pkg::IDX_W-1:0]     idx_reg;
    logic [orq_pkg::SLOT_W-1:0]    head_reg;
    logic [orq_pkg::SLOT_W-1:0]    tail_reg;
    logic [orq_pkg::COUNT_W-1:0]   count_reg;
    logic                          over_reg;
    logic                          acc_reg;
    logic                          empty_reg;
    logic [orq_pkg::BYTE_W-1:0]    eom_reg;
    logic [orq_pkg::BYTE_W-1:0]    slot_mem [orq_pkg::SLOT_COUNT * orq_pkg::MSG_BYTES];
    logic [orq_pkg::BYTE_W-1:0]    rdata_reg;

    logic                          out_valid_reg;
    logic [orq_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                          out_last_reg;
    logic                          out_empty_reg;
    logic [orq_pkg::EOM_W-1:0]     out_eom_reg;
    logic                          out_over_reg;
    logic                          out_acc_reg;
    logic [orq_pkg::COUNT_W-1:0]   out_count_reg;

    logic                          full;
    logic [orq_pkg::ADDR_W-1:0]    wr_addr;
    logic [orq_pkg::ADDR_W-1:0]    rd_addr;
    logic [orq_pkg::BYTE_W-1:0]    eom_byte;
    logic [orq_pkg::EOM_W-1:0]     eom_masked;
    logic [orq_pkg::COUNT_W-1:0]   vacant;

    assign full     = (count_reg != '0) && (head_reg == tail_reg);
    assign wr_addr  = orq_pkg::ADDR_W'(head_reg) * orq_pkg::ADDR_W'(orq_pkg::MSG_BYTES)
                    + orq_pkg::ADDR_W'(idx_reg);
    assign rd_addr  = orq_pkg::ADDR_W'(tail_reg) * orq_pkg::ADDR_W'(orq_pkg::MSG_BYTES)
                    + orq_pkg::ADDR_W'(idx_reg);
    assign eom_byte = (idx_reg == IDX_EOM) ? rdata_reg : eom_reg;
    assign eom_masked = orq_pkg::EOM_W'(eom_byte & orq_pkg::BYTE_W'(orq_pkg::EOM_MASK));

    assign status.fill_last = (fill_reg == IDX_MAX);
    assign status.gate_open = !(sampling_reg && !sending_reg);
    assign status.held_zero = (count_reg == '0);
    assign status.idx_last  = (idx_reg == IDX_MAX);
    assign status.out_free  = !out_valid_reg || m_tready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sampling_reg <= 1'b0;
            sending_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                orq_pkg::CFG_SAMPLING: sampling_reg <= cfg_wdata;
                orq_pkg::CFG_SENDING:  sending_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // staging buffer and byte index
    always_ff @(posedge aclk) begin
        if (cmd.stage_push) begin
            staging_reg[fill_reg] <= byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            idx_reg  <= '0;
        end else begin
            if (cmd.stage_push) begin
                fill_reg <= status.fill_last ? '0 : fill_reg + 1'b1;
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.copy_wr) begin
            slot_mem[wr_addr] <= staging_reg[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= slot_mem[rd_addr];
        end
    end

    // ring pointers and response flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            over_reg  <= 1'b0;
            acc_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end else begin
            if (cmd.flags_clr) begin
                over_reg  <= 1'b0;
                acc_reg   <= 1'b0;
                empty_reg <= 1'b0;
            end
            if (cmd.set_empty) begin
                empty_reg <= 1'b1;
            end
            if (cmd.commit) begin
                acc_reg  <= 1'b1;
                over_reg <= full;
                head_reg <= next_slot(head_reg);
                if (full) begin
                    tail_reg <= next_slot(tail_reg);
                end else begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.del) begin
                tail_reg  <= next_slot(tail_reg);
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte && (idx_reg == IDX_EOM)) begin
            eom_reg <= rdata_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_resp || cmd.load_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_resp) begin
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= empty_reg;
            out_eom_reg   <= '0;
            out_over_reg  <= over_reg;
            out_acc_reg   <= acc_reg;
            out_count_reg <= count_reg;
        end else if (cmd.load_byte) begin
            out_byte_reg  <= rdata_reg;
            out_last_reg  <= status.idx_last;
            out_empty_reg <= 1'b0;
            out_eom_reg   <= status.idx_last ? eom_masked : '0;
            out_over_reg  <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_count_reg <= count_reg;
        end
    end

    assign vacant   = orq_pkg::COUNT_W'(orq_pkg::SLOT_COUNT) - out_count_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {vacant, out_count_reg, out_eom_reg, out_byte_reg};
    assign m_tuser  = {out_acc_reg, out_over_reg, out_empty_reg};

endmodule

@@ hw/rtl/overwrite_ring_message_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_message_queue_core
// Ring of fixed-size message slots that overwrites the oldest when full.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_*       in         one request: push byte, read oldest or delete oldest
//  m_*       out        results: bytes of a read or one status result
//  cfg_*     in         sampling_on / sending_on writes
//
//  push without commit, delete, empty read: accept, then response
//  push that commits: accept, copy of MSG_BYTES bytes at one byte per cycle, response
//  read: accept, then per byte an address and a data state (registered read port)
//  m_tready low stretches any result cycle; reset clears pointers, counts, flags,
//  indices and configuration; the slot memory and staging buffer have no clearing pass
`include "overwrite_ring_message_queue_core_macros.svh"

module overwrite_ring_message_queue_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // data_byte
    input  logic [1:0]                  s_tuser,   // operation
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_byte, eom_index, message_count, vacant_count
    output logic [31:0]                 m_tdata,
    output logic                        m_tlast,   // last
    // empty_res, overwrote_oldest, stored_accepted
    output logic [2:0]                  m_tuser,
    input  logic                        cfg_we,
    input  logic [orq_pkg::CFG_W-1:0]   cfg_addr,
    input  logic                        cfg_wdata
);

    orq_pkg::cmd_t    cmd;
    orq_pkg::status_t status;
    orq_pkg::op_t     op;

    assign op = orq_pkg::op_t'(s_tuser);

    orq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    orq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .byte_in   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // counts always add up to the ring size
    `ORQ_ASSERT_NOW(a_counts_sum, aclk, aresetn, m_tvalid, ({1'b0, m_tdata[22:14]} + {1'b0, m_tdata[31:23]}) == 10'(orq_pkg::SLOT_COUNT))
    // an empty result is always the only one of its request
    `ORQ_ASSERT_NOW(a_empty_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast && (m_tdata[7:0] == 8'd0))
    // the block is not ready in the cycle after it accepts a request
    `ORQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // the slot memory is never written and read in the same cycle
    `ORQ_ASSERT_NOW(a_mem_port, aclk, aresetn, cmd.copy_wr, !cmd.rd_en && !cmd.stage_push)

endmodule
